>>> rtl/mtsm_pkg.sv
// ----------------------------------------------------------------------------
// mtsm_pkg: shared types and constants of the triggered sample mixer
// Sizes of the sample memory, voice state and mix arithmetic, and the command
// format passed from the front end to the voice engine.
// ----------------------------------------------------------------------------
package mtsm_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_SAMPLES = 4096;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int POS_W    = $clog2(MAX_SAMPLES);
  localparam int LEN_W    = POS_W + 1;
  localparam int MEM_AW   = SLOT_W + POS_W;
  localparam int MEM_DEPTH = SLOTS * MAX_SAMPLES;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 24;
  localparam int VSUM_W   = SAMPLE_W + SLOT_W;
  localparam int ACC_W    = MIX_W + 1;
  localparam int CHAN_W   = 5;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam logic [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SAMPLES);
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(1);

  // input item kinds
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_MIDI   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_LENGTH = 2'd3
  } mode_e;

  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_WRITE,
    CMD_LENGTH
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                    op;
    logic [SLOT_W-1:0]          slot;
    logic [POS_W-1:0]           address;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           length;
    logic signed [MIX_W-1:0]    left;
    logic signed [MIX_W-1:0]    right;
  } cmd_t;

  // command queue head as seen by the voice engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

>>> rtl/mtsm_ram.sv
// ----------------------------------------------------------------------------
// mtsm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/mtsm_front.sv
// ----------------------------------------------------------------------------
// mtsm_front: item intake, classification and command queue
// Holds the MIDI channel register, drops off-channel, non-note and out of
// range MIDI items, and queues the rest as commands for the voice engine.
// ----------------------------------------------------------------------------
module mtsm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           mode_i,
  input  logic [7:0]                           status_byte_i,
  input  logic [7:0]                           note_number_i,
  input  logic signed [mtsm_pkg::MIX_W-1:0]    left_in_i,
  input  logic signed [mtsm_pkg::MIX_W-1:0]    right_in_i,
  input  logic [3:0]                           slot_i,
  input  logic [11:0]                          address_i,
  input  logic signed [mtsm_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [12:0]                          length_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mtsm_pkg::CHAN_W-1:0]          cfg_data_i,
  output mtsm_pkg::cmd_head_t                  head_o,
  input  logic                                 head_pop_i
);

  logic [mtsm_pkg::CHAN_W-1:0]    midi_channel_q;
  mtsm_pkg::cmd_t                 fifo_q [mtsm_pkg::CMD_DEPTH];
  logic [mtsm_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mtsm_pkg::CMD_PTR_W:0]   count_q;

  logic                 accept;
  logic                 keep;
  logic                 deq;
  logic                 chan_hit;
  logic                 note_ok;
  mtsm_pkg::cmd_t       cmd;

  assign cfg_ready_o = 1'b1;
  assign full        = (count_q == (mtsm_pkg::CMD_PTR_W+1)'(mtsm_pkg::CMD_DEPTH));
  assign accept      = push && !full;
  assign deq         = head_pop_i && (count_q != '0);

  assign chan_hit = ({1'b0, status_byte_i[3:0]} + mtsm_pkg::CHAN_W'(1)) == midi_channel_q;
  assign note_ok  = note_number_i < 8'(mtsm_pkg::SLOTS);

  always_comb begin
    cmd         = '0;
    cmd.op      = mtsm_pkg::CMD_TICK;
    cmd.slot    = slot_i[mtsm_pkg::SLOT_W-1:0];
    cmd.address = address_i[mtsm_pkg::POS_W-1:0];
    cmd.sample  = sample_value_i;
    cmd.length  = (length_i > mtsm_pkg::LEN_MAX) ? mtsm_pkg::LEN_MAX : length_i;
    cmd.left    = left_in_i;
    cmd.right   = right_in_i;
    keep        = 1'b0;
    case (mode_i)
      mtsm_pkg::MODE_TICK: begin
        keep = 1'b1;
      end
      mtsm_pkg::MODE_MIDI: begin
        cmd.slot = note_number_i[mtsm_pkg::SLOT_W-1:0];
        if (status_byte_i[7:4] == mtsm_pkg::MIDI_NOTE_ON) begin
          cmd.op = mtsm_pkg::CMD_NOTE_ON;
          keep   = chan_hit && note_ok;
        end else if (status_byte_i[7:4] == mtsm_pkg::MIDI_NOTE_OFF) begin
          cmd.op = mtsm_pkg::CMD_NOTE_OFF;
          keep   = chan_hit && note_ok;
        end
      end
      mtsm_pkg::MODE_WRITE: begin
        cmd.op = mtsm_pkg::CMD_WRITE;
        keep   = 1'b1;
      end
      mtsm_pkg::MODE_LENGTH: begin
        cmd.op = mtsm_pkg::CMD_LENGTH;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      midi_channel_q <= mtsm_pkg::CHAN_RESET;
      wr_ptr_q       <= '0;
      rd_ptr_q       <= '0;
      count_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        midi_channel_q <= cfg_data_i;
      end
      if (accept && keep) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (mtsm_pkg::CMD_PTR_W+1)'(accept && keep)
                         - (mtsm_pkg::CMD_PTR_W+1)'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

>>> rtl/mtsm_back.sv
// ----------------------------------------------------------------------------
// mtsm_back: voice engine and mixer
// Executes queued commands: sample and length loads, note on and off, and
// ticks that scan all voices one per cycle through the sample memory.
// ----------------------------------------------------------------------------
module mtsm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtsm_pkg::cmd_head_t               head_i,
  output logic                              head_pop_o,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mtsm_pkg::MIX_W-1:0] left_out_o,
  output logic signed [mtsm_pkg::MIX_W-1:0] right_out_o,
  output logic                              clipped_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                              state_q;
  logic [mtsm_pkg::SLOT_W-1:0]         idx_q;
  logic                                hit_q;
  logic [mtsm_pkg::SLOTS-1:0]          playing_q;
  logic [mtsm_pkg::SLOTS-1:0]          present_q;
  logic [mtsm_pkg::POS_W-1:0]          pos_q [mtsm_pkg::SLOTS];
  logic [mtsm_pkg::LEN_W-1:0]          len_q [mtsm_pkg::SLOTS];
  logic signed [mtsm_pkg::VSUM_W-1:0]  vsum_q;
  logic signed [mtsm_pkg::MIX_W-1:0]   left_q, right_q;
  logic                                out_valid_q;

  mtsm_pkg::cmd_t                      cmd;
  logic                                ram_we;
  logic [mtsm_pkg::MEM_AW-1:0]         ram_waddr, ram_raddr;
  logic [mtsm_pkg::SAMPLE_W-1:0]       ram_rdata;
  logic [mtsm_pkg::POS_W-1:0]          cur_pos;
  logic [mtsm_pkg::LEN_W-1:0]          cur_len;
  logic [mtsm_pkg::LEN_W-1:0]          pos_inc;
  logic                                hit;
  logic                                out_free;
  logic signed [mtsm_pkg::ACC_W-1:0]   sum_l, sum_r;
  logic                                ovf_l, ovf_r;
  logic [mtsm_pkg::MIX_W-1:0]          sat_l, sat_r;

  assign cmd        = head_i.cmd;
  assign head_pop_o = (state_q == S_IDLE) && head_i.valid;
  assign ram_we     = head_pop_o && (cmd.op == mtsm_pkg::CMD_WRITE);
  assign ram_waddr  = {cmd.slot, cmd.address};

  assign cur_pos   = pos_q[idx_q];
  assign cur_len   = len_q[idx_q];
  assign pos_inc   = {1'b0, cur_pos} + mtsm_pkg::LEN_W'(1);
  assign hit       = playing_q[idx_q] && ({1'b0, cur_pos} < cur_len);
  assign ram_raddr = {idx_q, cur_pos};

  mtsm_ram #(
    .WIDTH (mtsm_pkg::SAMPLE_W),
    .DEPTH (mtsm_pkg::MEM_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd.sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // final mix: one wide add per side, then saturate
  assign sum_l = mtsm_pkg::ACC_W'(left_q) + mtsm_pkg::ACC_W'(vsum_q);
  assign sum_r = mtsm_pkg::ACC_W'(right_q) + mtsm_pkg::ACC_W'(vsum_q);
  assign ovf_l = sum_l[mtsm_pkg::ACC_W-1] != sum_l[mtsm_pkg::ACC_W-2];
  assign ovf_r = sum_r[mtsm_pkg::ACC_W-1] != sum_r[mtsm_pkg::ACC_W-2];
  assign sat_l = ovf_l ? (sum_l[mtsm_pkg::ACC_W-1] ? mtsm_pkg::MIX_MIN : mtsm_pkg::MIX_MAX)
                       : sum_l[mtsm_pkg::MIX_W-1:0];
  assign sat_r = ovf_r ? (sum_r[mtsm_pkg::ACC_W-1] ? mtsm_pkg::MIX_MIN : mtsm_pkg::MIX_MAX)
                       : sum_r[mtsm_pkg::MIX_W-1:0];

  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      playing_q   <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
      vsum_q      <= '0;
      for (int i = 0; i < mtsm_pkg::SLOTS; i++) begin
        pos_q[i] <= '0;
        len_q[i] <= '0;
      end
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      // accumulate the sample read for the previous voice
      if (hit_q) begin
        vsum_q <= vsum_q + mtsm_pkg::VSUM_W'($signed(ram_rdata));
      end
      hit_q <= (state_q == S_SCAN) && hit;
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            case (cmd.op)
              mtsm_pkg::CMD_TICK: begin
                left_q  <= cmd.left;
                right_q <= cmd.right;
                vsum_q  <= '0;
                idx_q   <= '0;
                state_q <= S_SCAN;
              end
              mtsm_pkg::CMD_NOTE_ON, mtsm_pkg::CMD_NOTE_OFF: begin
                if (present_q[cmd.slot]) begin
                  playing_q[cmd.slot] <= (cmd.op == mtsm_pkg::CMD_NOTE_ON);
                  pos_q[cmd.slot]     <= '0;
                end
              end
              mtsm_pkg::CMD_LENGTH: begin
                len_q[cmd.slot]     <= cmd.length;
                present_q[cmd.slot] <= (cmd.length != '0);
                playing_q[cmd.slot] <= 1'b0;
                pos_q[cmd.slot]     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (playing_q[idx_q]) begin
            // advance; stop and rewind at the end of the sample
            if (hit && (pos_inc < cur_len)) begin
              pos_q[idx_q] <= pos_inc[mtsm_pkg::POS_W-1:0];
            end else begin
              playing_q[idx_q] <= 1'b0;
              pos_q[idx_q]     <= '0;
            end
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == mtsm_pkg::SLOT_W'(mtsm_pkg::SLOTS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            left_out_o  <= sat_l;
            right_out_o <= sat_r;
            clipped_o   <= ovf_l || ovf_r;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE)
    else $error("sample write outside idle");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop_o && cmd.op == mtsm_pkg::CMD_TICK) |=> (state_q == S_SCAN && idx_q == '0))
    else $error("tick did not start scan at voice zero");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && playing_q[idx_q]) |-> ({1'b0, cur_pos} < cur_len))
    else $error("playing voice beyond its length");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside mix completion");

  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("sample accumulate outside scan");

endmodule

>>> rtl/midi_triggered_sample_mixer.sv
// ----------------------------------------------------------------------------
// midi_triggered_sample_mixer: MIDI-driven one-shot sample player and mixer
// Sixteen sample slots in one memory, started and stopped by note messages,
// mixed into a stereo stream once per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on a queue-style port: a transaction happens when push is
//   high and full is low. Mode selects tick, MIDI message, sample write or
//   slot length. Only ticks produce a result; it appears on left_out_o,
//   right_out_o and clipped_o while empty is low and leaves on pop.
//   The channel register is written through cfg_valid_i/cfg_data_i, always
//   ready. The user must write it only while no item is in flight; the
//   block does not check this. Items first land in a four-entry command
//   queue. The voice engine takes a load or MIDI command in its idle state.
//   A tick is dequeued in idle, scans the voices one per cycle through the
//   single read port of the sample memory, collects the last read in drain
//   and mixes and saturates in done, then takes the next command in idle.
//   A result waits in an output register; a stalled receiver holds the next
//   tick at its mix step while the intake keeps filling the queue.
//   Reset clears the queues, all slot lengths and voices, and sets the
//   channel to 1; sample memory contents are undefined until written.
// ----------------------------------------------------------------------------
module midi_triggered_sample_mixer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           mode_i,
  input  logic [7:0]                           status_byte_i,
  input  logic [7:0]                           note_number_i,
  input  logic signed [mtsm_pkg::MIX_W-1:0]    left_in_i,
  input  logic signed [mtsm_pkg::MIX_W-1:0]    right_in_i,
  input  logic [3:0]                           slot_i,
  input  logic [11:0]                          address_i,
  input  logic signed [mtsm_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [12:0]                          length_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [mtsm_pkg::MIX_W-1:0]    left_out_o,
  output logic signed [mtsm_pkg::MIX_W-1:0]    right_out_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mtsm_pkg::CHAN_W-1:0]          cfg_data_i
);

  mtsm_pkg::cmd_head_t head;
  logic                head_pop;

  mtsm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .status_byte_i  (status_byte_i),
    .note_number_i  (note_number_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .slot_i         (slot_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .length_i       (length_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .head_o         (head),
    .head_pop_i     (head_pop)
  );

  mtsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_pop_o  (head_pop),
    .empty       (empty),
    .pop         (pop),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .clipped_o   (clipped_o)
  );

endmodule

>>> tb/midi_triggered_sample_mixer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_triggered_sample_mixer_test: self-checking bench for the sample mixer
// Loads sample slots, plays them from note messages and checks every mixed
// tick result against an in-bench voice model. Directed corner cases, a slot
// with an oversized length, then random traffic under several channel
// settings, with random idle cycles on the item and result sides.
// ----------------------------------------------------------------------------
module midi_triggered_sample_mixer_test;
  import mtsm_pkg::*;

  localparam int MIX_TOP       = 8388607;
  localparam int MIX_BOTTOM    = -8388608;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 225;
  localparam logic [3:0] CTRL_CHANGE = 4'hB;

  typedef struct {
    mode_e                      mode;
    logic [7:0]                 status;
    logic [7:0]                 note;
    logic signed [MIX_W-1:0]    left_in;
    logic signed [MIX_W-1:0]    right_in;
    logic [3:0]                 slot;
    logic [11:0]                address;
    logic signed [SAMPLE_W-1:0] sample;
    logic [12:0]                length;
  } sampler_item_t;

  typedef struct {
    logic signed [MIX_W-1:0] left;
    logic signed [MIX_W-1:0] right;
    logic                    clipped;
  } mix_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic [1:0]                 mode_i = '0;
  logic [7:0]                 status_byte_i = '0;
  logic [7:0]                 note_number_i = '0;
  logic signed [MIX_W-1:0]    left_in_i = '0;
  logic signed [MIX_W-1:0]    right_in_i = '0;
  logic [3:0]                 slot_i = '0;
  logic [11:0]                address_i = '0;
  logic signed [SAMPLE_W-1:0] sample_value_i = '0;
  logic [12:0]                length_i = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [MIX_W-1:0]    left_out_o;
  logic signed [MIX_W-1:0]    right_out_o;
  logic                       clipped_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CHAN_W-1:0]          cfg_data_i = '0;

  midi_triggered_sample_mixer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .status_byte_i  (status_byte_i),
    .note_number_i  (note_number_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .slot_i         (slot_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .length_i       (length_i),
    .empty          (empty),
    .pop            (pop),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .clipped_o      (clipped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // voice model state
  logic signed [SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
  bit [LEN_W-1:0]             slot_size [SLOTS];
  bit                         voice_active [SLOTS];
  bit [POS_W-1:0]             voice_idx [SLOTS];
  bit [CHAN_W-1:0]            listen_channel = CHAN_RESET;

  // stimulus bookkeeping: which words hold data, and the written prefix per slot
  bit          wave_known [MEM_DEPTH];
  int unsigned known_len [SLOTS];

  sampler_item_t pending_items[$];
  mix_result_t   expected_mix[$];
  sampler_item_t cur_item;
  bit            holding_item = 1'b0;
  int            gap_left = 0;
  int            stall_left = 0;
  bit            drive_burst = 1'b0;
  bit            pop_burst = 1'b0;
  int            mismatch_count = 0;

  function automatic int pick_idle(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [MIX_W-1:0] clamp_mix(input int v);
    if (v > MIX_TOP) return MIX_W'(MIX_TOP);
    if (v < MIX_BOTTOM) return MIX_W'(MIX_BOTTOM);
    return MIX_W'(v);
  endfunction

  // advance the voice model by one accepted transaction
  function automatic void sampler_step(input sampler_item_t it);
    int          left_acc;
    int          right_acc;
    bit [LEN_W-1:0] next_pos;
    mix_result_t res;
    case (it.mode)
      MODE_MIDI: begin
        if (({1'b0, it.status[3:0]} + 5'd1) == listen_channel &&
            (it.status[7:4] == MIDI_NOTE_ON || it.status[7:4] == MIDI_NOTE_OFF) &&
            it.note < SLOTS && slot_size[it.note[3:0]] != 0) begin
          voice_active[it.note[3:0]] = (it.status[7:4] == MIDI_NOTE_ON);
          voice_idx[it.note[3:0]] = '0;
        end
      end
      MODE_WRITE: begin
        wave_mem[{it.slot, it.address}] = it.sample;
      end
      MODE_LENGTH: begin
        slot_size[it.slot] = (it.length > MAX_SAMPLES) ? LEN_MAX : it.length;
        voice_active[it.slot] = 1'b0;
        voice_idx[it.slot] = '0;
      end
      default: begin
        left_acc = it.left_in;
        right_acc = it.right_in;
        for (int v = 0; v < SLOTS; v++) begin
          if (voice_active[v]) begin
            if ({1'b0, voice_idx[v]} >= slot_size[v]) begin
              voice_active[v] = 1'b0;
              voice_idx[v] = '0;
            end else begin
              left_acc += wave_mem[{4'(v), voice_idx[v]}];
              right_acc += wave_mem[{4'(v), voice_idx[v]}];
              next_pos = {1'b0, voice_idx[v]} + 1'b1;
              if (next_pos >= slot_size[v]) begin
                voice_active[v] = 1'b0;
                voice_idx[v] = '0;
              end else begin
                voice_idx[v] = next_pos[POS_W-1:0];
              end
            end
          end
        end
        res.left = clamp_mix(left_acc);
        res.right = clamp_mix(right_acc);
        res.clipped = (left_acc > MIX_TOP) || (left_acc < MIX_BOTTOM) ||
                      (right_acc > MIX_TOP) || (right_acc < MIX_BOTTOM);
        expected_mix.insert(expected_mix.size(), res);
      end
    endcase
  endfunction

  // every field random; callers override the ones that matter
  function automatic sampler_item_t noise_item();
    sampler_item_t it;
    it.mode     = mode_e'($urandom_range(0, 3));
    it.status   = 8'($urandom());
    it.note     = 8'($urandom());
    it.left_in  = MIX_W'($urandom());
    it.right_in = MIX_W'($urandom());
    it.slot     = 4'($urandom());
    it.address  = 12'($urandom());
    it.sample   = SAMPLE_W'($urandom());
    it.length   = 13'($urandom());
    return it;
  endfunction

  function automatic void queue_write(input logic [3:0] s, input logic [11:0] a,
                                      input logic [SAMPLE_W-1:0] val);
    sampler_item_t it;
    it = noise_item();
    it.mode = MODE_WRITE;
    it.slot = s;
    it.address = a;
    it.sample = val;
    wave_known[{s, a}] = 1'b1;
    while (known_len[s] < MAX_SAMPLES && wave_known[{s, 12'(known_len[s])}])
      known_len[s]++;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // callers keep playback inside the written prefix: no empty word is ever read
  function automatic void queue_length(input logic [3:0] s, input logic [12:0] len);
    sampler_item_t it;
    it = noise_item();
    it.mode = MODE_LENGTH;
    it.slot = s;
    it.length = len;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_midi(input logic [7:0] status, input logic [7:0] note);
    sampler_item_t it;
    it = noise_item();
    it.mode = MODE_MIDI;
    it.status = status;
    it.note = note;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_tick(input logic [MIX_W-1:0] l, input logic [MIX_W-1:0] r);
    sampler_item_t it;
    it = noise_item();
    it.mode = MODE_TICK;
    it.left_in = l;
    it.right_in = r;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic [MIX_W-1:0] edge_mix();
    if ($urandom_range(0, 1) == 0) return MIX_W'(MIX_TOP - int'($urandom_range(0, 70000)));
    return MIX_W'(MIX_BOTTOM + int'($urandom_range(0, 70000)));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return SAMPLE_W'($urandom());
  endfunction

  function automatic void queue_random_item();
    int          r;
    logic [3:0]  s;
    logic [3:0]  nib;
    int unsigned lim;
    int          q;
    r = $urandom_range(0, 99);
    s = 4'($urandom());
    if (r < 45) begin
      if ($urandom_range(0, 9) == 0) queue_tick(edge_mix(), edge_mix());
      else queue_tick(MIX_W'($urandom()), MIX_W'($urandom()));
    end else if (r < 75) begin
      if ($urandom_range(0, 4) != 0) begin
        if (listen_channel >= 1 && listen_channel <= 16) nib = 4'(listen_channel - 1'b1);
        else nib = 4'($urandom());
        queue_midi({($urandom_range(0, 99) < 65) ? MIDI_NOTE_ON : MIDI_NOTE_OFF, nib},
                   ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, SLOTS - 1))
                                              : 8'($urandom()));
      end else begin
        queue_midi(8'($urandom()), 8'($urandom()));
      end
    end else if (r < 90) begin
      if ($urandom_range(0, 99) < 60 && known_len[s] < MAX_SAMPLES)
        queue_write(s, 12'(known_len[s]), pick_sample());
      else
        queue_write(s, 12'($urandom()), pick_sample());
    end else begin
      lim = known_len[s];
      q = $urandom_range(0, 9);
      if (lim == 0 || q == 0) queue_length(s, '0);
      else if (lim == MAX_SAMPLES && q == 1) queue_length(s, 13'($urandom_range(0, 8191)));
      else queue_length(s, 13'($urandom_range(1, (lim < 48) ? lim : 48)));
    end
  endfunction

  // item driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sampler_step(cur_item);
        holding_item = 1'b0;
      end
      if (!holding_item) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding_item = 1'b1;
          gap_left = pick_idle(drive_burst);
          if ($urandom_range(0, 99) < 3) drive_burst = !drive_burst;
          mode_i         <= cur_item.mode;
          status_byte_i  <= cur_item.status;
          note_number_i  <= cur_item.note;
          left_in_i      <= cur_item.left_in;
          right_in_i     <= cur_item.right_in;
          slot_i         <= cur_item.slot;
          address_i      <= cur_item.address;
          sample_value_i <= cur_item.sample;
          length_i       <= cur_item.length;
        end
      end
      push <= holding_item;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    mix_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_mix.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected mix result L=%0d R=%0d clip=%0b",
                     $time, left_out_o, right_out_o, clipped_o);
        end else begin
          want = expected_mix.pop_front();
          if (left_out_o !== want.left || right_out_o !== want.right ||
              clipped_o !== want.clipped) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mix mismatch: expected L=%0d R=%0d clip=%0b, got L=%0d R=%0d clip=%0b",
                       $time, want.left, want.right, want.clipped,
                       left_out_o, right_out_o, clipped_o);
          end
        end
        stall_left = pick_idle(pop_burst);
        if ($urandom_range(0, 99) < 3) pop_burst = !pop_burst;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // hold until every item is taken and every result is out, then let trailing
  // load or MIDI commands drain from the command queue
  task automatic wait_idle();
    while (pending_items.size() != 0 || holding_item || expected_mix.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel(input logic [CHAN_W-1:0] ch);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ch;
    do @(posedge clk_i); while (!cfg_ready_o);
    listen_channel = ch;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CHAN_W-1:0] channel_plan [6];
    channel_plan = '{5'd16, 5'd1, 5'd0, 5'd9, 5'd31, 5'($urandom_range(1, 16))};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners on the reset channel
    queue_write(4'd0, 12'd0, 16'h7FFF);
    queue_write(4'd0, 12'd1, 16'h8000);
    queue_write(4'd0, 12'd2, 16'h0001);
    queue_write(4'd1, 12'd0, 16'h7FFF);
    queue_write(4'd2, 12'd4095, 16'hFFFF);
    queue_length(4'd0, 13'd3);
    queue_length(4'd1, 13'd1);
    queue_tick('0, '0);
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd0);
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd1);
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd2);          // absent slot
    queue_midi({MIDI_NOTE_ON, 4'h1}, 8'd2);          // wrong channel
    queue_midi({CTRL_CHANGE, 4'h0}, 8'd2);           // not a note message
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'hF0);         // note beyond the slots
    queue_tick(MIX_W'(MIX_TOP), MIX_W'(MIX_BOTTOM));
    queue_tick('0, '0);
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd0);          // retrigger while playing
    queue_tick(MIX_W'(MIX_BOTTOM), MIX_W'(MIX_BOTTOM));
    queue_midi({MIDI_NOTE_OFF, 4'h0}, 8'd0);
    queue_tick(MIX_W'(MIX_TOP), MIX_W'(MIX_TOP));
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd0);
    queue_length(4'd0, 13'd3);                       // length write stops the voice
    queue_tick('0, '0);

    // oversized length saturates; play a few words, stop, then drop the slot
    for (int a = 0; a < 4; a++) queue_write(4'd15, 12'(a), pick_sample());
    queue_length(4'd15, 13'h1FFF);
    queue_midi({MIDI_NOTE_ON, 4'h0}, 8'd15);
    repeat (3) queue_tick(MIX_W'($urandom()), MIX_W'($urandom()));
    queue_midi({MIDI_NOTE_OFF, 4'h0}, 8'd15);
    queue_length(4'd15, '0);

    foreach (channel_plan[p]) begin
      wait_idle();
      write_channel(channel_plan[p]);
      repeat (PHASE_ITEMS) queue_random_item();
    end
    wait_idle();

    if (mismatch_count == 0 && expected_mix.size() == 0)
      $display("midi_triggered_sample_mixer_test: PASS");
    else
      $display("midi_triggered_sample_mixer_test: FAIL");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("midi_triggered_sample_mixer_test: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/mtsm_pkg.sv
rtl/mtsm_ram.sv
rtl/mtsm_front.sv
rtl/mtsm_back.sv
rtl/midi_triggered_sample_mixer.sv
tb/midi_triggered_sample_mixer_test.sv
